[hw/rtl/isc_pkg.sv]
// Package with opcode, funct, rt and address constants, the skip reason type and the result struct for the classifier.
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

    typedef enum logic [1:0] {
        REASON_NONE     = 2'd0,
        REASON_MEM      = 2'd1,
        REASON_EXC      = 2'd2,
        REASON_OVERFLOW = 2'd3
    } t_reason;

    typedef struct packed {
        logic        skip;
        t_reason     reason;
        logic [31:0] eff_addr;
    } t_result;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_DADDI   = 6'h18;
    localparam logic [5:0] OP_LDL     = 6'h1a;
    localparam logic [5:0] OP_LDR     = 6'h1b;
    localparam logic [5:0] OP_LQ      = 6'h1e;
    localparam logic [5:0] OP_SQ      = 6'h1f;
    localparam logic [5:0] OP_MEM_LO  = 6'h20;
    localparam logic [5:0] OP_MEM_HI  = 6'h2f;
    localparam logic [5:0] OP_LD      = 6'h37;
    localparam logic [5:0] OP_SD      = 6'h3f;

    // SPECIAL funct codes
    localparam logic [5:0] FN_SYSCALL  = 6'h0c;
    localparam logic [5:0] FN_BREAK    = 6'h0d;
    localparam logic [5:0] FN_TRAP_LO  = 6'h30;
    localparam logic [5:0] FN_TRAP_HI  = 6'h36;
    localparam logic [5:0] FN_ADD      = 6'h20;
    localparam logic [5:0] FN_SUB      = 6'h22;
    localparam logic [5:0] FN_DADD     = 6'h2c;
    localparam logic [5:0] FN_DSUB     = 6'h2e;

    // REGIMM trap codes in the rt field
    localparam logic [4:0] RT_TRAP_LO = 5'h08;
    localparam logic [4:0] RT_TRAP_HI = 5'h0e;

    // Address map
    localparam logic [31:0] SCRATCH_MASK = 32'hFFFF_C000;
    localparam logic [31:0] SCRATCH_BASE = 32'h7000_0000;
    localparam logic [31:0] MIRROR_MASK  = 32'h1FFF_FFFF;
    localparam logic [31:0] RAM_SIZE     = 32'h0200_0000;

endpackage

`default_nettype wire

[hw/rtl/instruction_skip_classifier.sv]
// Top level of the instruction skip classifier: input register, decode, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one instruction word with
//   the 64-bit values of its rs and rt registers. A transfer happens at a
//   rising edge with valid high and stall low.
//   Output channel (o_out_valid / i_out_stall) carries the skip flag, the
//   reason code and the effective address, one result per input transfer,
//   in input order.
//   Path: the input transfer reaches o_out_valid through the input register
//   and then the result register.
//   Throughput: one instruction per cycle when not stalled; the decode and one
//   64-bit adder with its overflow test sit between the two registers.
//   Stall: the two stages advance together. When a result waits and the
//   receiver stalls, both stages hold and o_in_stall rises in the same cycle;
//   an empty result register keeps the pipe moving even under stall.
//   Reset: i_rst_n low at a clock edge drops both valid bits; no results are
//   pending afterwards. The payload and result data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module instruction_skip_classifier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_instruction,
    input  wire logic [63:0] i_rs_value,
    input  wire logic [63:0] i_rt_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_skip,
    output logic [1:0]       o_skip_reason,
    output logic [31:0]      o_effective_address
);

    logic              advance;
    logic              r_s1_vld;
    logic [31:0]       r_instr;
    logic [63:0]       r_rs;
    logic [63:0]       r_rt;
    logic              r_out_vld;
    isc_pkg::t_result  r_result;
    isc_pkg::t_result  n_result;

    // Advance whenever the result register is empty or being drained.
    assign advance    = !r_out_vld || !i_out_stall;
    assign o_in_stall = !advance;

    // Input register: capture payload on every advance, valid follows the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (advance) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_instr <= i_instruction;
            r_rs    <= i_rs_value;
            r_rt    <= i_rt_value;
        end
    end

    isc_classify u_classify (
        .i_instruction (r_instr),
        .i_rs_value    (r_rs),
        .i_rt_value    (r_rt),
        .o_result      (n_result)
    );

    // Result register: hold while the receiver stalls a waiting result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_skip              = r_result.skip;
    assign o_skip_reason       = r_result.reason;
    assign o_effective_address = r_result.eff_addr;

    // Skip flag agrees with the reason code on every presented result.
    a_skip_matches_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_skip == (o_skip_reason != isc_pkg::REASON_NONE)))
        else $error("skip flag disagrees with reason code");

    // An accepted item reaches the input register.
    a_accept_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_vld)
        else $error("accepted item lost at input register");

    // Input stalls only while a result waits on a stalled receiver.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_vld && i_out_stall))
        else $error("input stalled without back pressure");

    // A pending first-stage item moves into the result register on advance.
    a_stage_moves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && advance) |=> o_out_valid)
        else $error("first-stage item dropped");

    // A blocked item in the first stage stays there.
    a_stage_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !advance) |=> (r_s1_vld && $stable(r_instr)))
        else $error("first-stage item changed under stall");

endmodule

`default_nettype wire

[hw/rtl/isc_classify.sv]
// Combinational decode of one instruction into skip flag, reason and effective address.
`timescale 1ns / 1ps
`default_nettype none

module isc_classify (
    input  wire logic [31:0]   i_instruction,
    input  wire logic [63:0]   i_rs_value,
    input  wire logic [63:0]   i_rt_value,
    output isc_pkg::t_result   o_result
);

    logic [5:0]  primary;
    logic [5:0]  funct;
    logic [4:0]  rt_field;
    logic [31:0] imm32;
    logic [63:0] imm64;
    logic [31:0] eff_addr;
    logic        is_mem;
    logic        in_map;
    logic        is_exc;
    logic [31:0] a32;
    logic [31:0] b32;
    logic [31:0] s32;
    logic [63:0] b64;
    logic [63:0] s64;
    logic        use32;
    logic        use64;
    logic        ovf;

    assign primary  = i_instruction[31:26];
    assign funct    = i_instruction[5:0];
    assign rt_field = i_instruction[20:16];
    assign imm32    = {{16{i_instruction[15]}}, i_instruction[15:0]};
    assign imm64    = {{32{imm32[31]}}, imm32};
    assign eff_addr = i_rs_value[31:0] + imm32;

    assign is_mem = ((primary >= isc_pkg::OP_MEM_LO) && (primary <= isc_pkg::OP_MEM_HI))
                 || (primary == isc_pkg::OP_LDL) || (primary == isc_pkg::OP_LDR)
                 || (primary == isc_pkg::OP_LQ)  || (primary == isc_pkg::OP_SQ)
                 || (primary == isc_pkg::OP_LD)  || (primary == isc_pkg::OP_SD);

    assign in_map = ((eff_addr & isc_pkg::SCRATCH_MASK) == isc_pkg::SCRATCH_BASE)
                 || ((eff_addr & isc_pkg::MIRROR_MASK) < isc_pkg::RAM_SIZE);

    always_comb begin
        is_exc = 1'b0;
        if (primary == isc_pkg::OP_SPECIAL) begin
            is_exc = (funct == isc_pkg::FN_SYSCALL) || (funct == isc_pkg::FN_BREAK)
                  || ((funct >= isc_pkg::FN_TRAP_LO) && (funct <= isc_pkg::FN_TRAP_HI));
        end else if (primary == isc_pkg::OP_REGIMM) begin
            is_exc = (rt_field >= isc_pkg::RT_TRAP_LO) && (rt_field <= isc_pkg::RT_TRAP_HI);
        end
    end

    // Pick the second operand; subtracts add the two's complement negation.
    always_comb begin
        use32 = 1'b0;
        use64 = 1'b0;
        b32   = imm32;
        b64   = imm64;
        if (primary == isc_pkg::OP_ADDI) begin
            use32 = 1'b1;
        end else if (primary == isc_pkg::OP_DADDI) begin
            use64 = 1'b1;
        end else if (primary == isc_pkg::OP_SPECIAL) begin
            case (funct)
                isc_pkg::FN_ADD: begin
                    use32 = 1'b1;
                    b32   = i_rt_value[31:0];
                end
                isc_pkg::FN_SUB: begin
                    use32 = 1'b1;
                    b32   = 32'd0 - i_rt_value[31:0];
                end
                isc_pkg::FN_DADD: begin
                    use64 = 1'b1;
                    b64   = i_rt_value;
                end
                isc_pkg::FN_DSUB: begin
                    use64 = 1'b1;
                    b64   = 64'd0 - i_rt_value;
                end
                default: begin
                    use32 = 1'b0;
                    use64 = 1'b0;
                end
            endcase
        end
    end

    assign a32 = i_rs_value[31:0];
    assign s32 = a32 + b32;
    assign s64 = i_rs_value + b64;

    assign ovf = (use32 && (~(a32[31] ^ b32[31]) & (a32[31] ^ s32[31])))
              || (use64 && (~(i_rs_value[63] ^ b64[63]) & (i_rs_value[63] ^ s64[63])));

    always_comb begin
        o_result.eff_addr = eff_addr;
        if (is_mem && !in_map) begin
            o_result.reason = isc_pkg::REASON_MEM;
        end else if (is_exc) begin
            o_result.reason = isc_pkg::REASON_EXC;
        end else if (ovf) begin
            o_result.reason = isc_pkg::REASON_OVERFLOW;
        end else begin
            o_result.reason = isc_pkg::REASON_NONE;
        end
        o_result.skip = (o_result.reason != isc_pkg::REASON_NONE);
    end

endmodule

`default_nettype wire
